/* design/crcfse_pkg.sv */
// ----------------------------------------------------------------------------
// crcfse_pkg: shared types and constants for the CRC-16 frame encoder
// Defines the CRC-16/MODBUS constants, the byte-wise CRC update and the
// per-request work entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfse_pkg;

  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'hA001;  // reflected 0x8005
  localparam logic [7:0]  EscapeReset = 8'h90;

  // One accepted request: up to three frame bytes, each possibly doubled.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [2:0] dbl;        // doubling flag per byte, bit k for byte k
    logic       frame_end;  // bytes 1 and 2 hold the CRC
  } work_t;

  // Byte-wise reflected CRC update, eight shift/xor steps.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/crc16_frame_stuffing_encoder_top.sv */
// ----------------------------------------------------------------------------
// crc16_frame_stuffing_encoder_top: CRC-16/MODBUS frame encoder with byte stuffing
// Appends the frame CRC and doubles escape bytes found after the frame header.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side (s_axis_*): one payload byte per request; tlast marks the final
//   payload byte of a frame. Master side (m_axis_*): bytes for the serial line;
//   tlast marks the last byte caused by one input request, tuser[0] marks the
//   final byte of the frame (last CRC byte, or its second copy).
//   A request yields 1 or 2 output bytes, or 3 to 6 when it ends the frame
//   (payload byte + CRC low + CRC high, each doubled when it equals the escape
//   code and sits at frame position HEADER_UNSTUFFED or later).
//   A request is held in the work register, its bytes then pass through the
//   output register. Throughput: one output byte per cycle while
//   m_axis_tready is high, set by the single output register. A request holds
//   the work register until its last byte moves on; with single byte results
//   a new request is taken every cycle while m_axis_tready is high.
//   Stall: with the output register full and m_axis_tready low, it holds, the
//   work register stops, and s_axis_tready drops once the work register is full.
//   Reset: CRC = 0xFFFF, position = 0, escape code = 0x90, all queues empty.
//   cfg_we_i/cfg_wdata_i write the escape code; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_stuffing_encoder_top #(
  parameter int HEADER_UNSTUFFED = 3
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  // input stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic       s_axis_tlast,   // frame_end
  // output stream
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] tx_byte
  output logic            m_axis_tlast,   // run_last
  output logic [0:0]      m_axis_tuser    // [0] frame_done
);

  // Position counter saturates at the header length.
  localparam int PosW = (HEADER_UNSTUFFED < 1) ? 1 : $clog2(HEADER_UNSTUFFED + 1);
  localparam logic [PosW-1:0] HdrPos = PosW'(HEADER_UNSTUFFED);

  function automatic logic [PosW-1:0] pos_next(input logic [PosW-1:0] p);
    return (p >= HdrPos) ? p : p + PosW'(1);
  endfunction

  // Frame state and configuration
  logic [15:0]     crc_q, crc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      escape_q;

  // Work register: one accepted request being emitted
  logic               work_valid_q, work_valid_d;
  crcfse_pkg::work_t  work_q, work_d;
  logic [1:0]         idx_q, idx_d;    // byte within the request
  logic               copy_q, copy_d;  // second copy of a doubled byte

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic       out_done_q, out_done_d;

  // Current result selection
  logic [7:0] cur_byte;
  logic       cur_dbl;
  logic       byte_end;   // last copy of the current byte
  logic       item_end;   // last result of the request
  logic       adv;        // a result moves into the output register
  logic       accept;

  // Accept-time computation
  logic [15:0]     crc_new;
  logic [PosW-1:0] pos1, pos2;

  always_comb begin
    unique case (idx_q)
      2'd0:    begin cur_byte = work_q.byte0; cur_dbl = work_q.dbl[0]; end
      2'd1:    begin cur_byte = work_q.byte1; cur_dbl = work_q.dbl[1]; end
      2'd2:    begin cur_byte = work_q.byte2; cur_dbl = work_q.dbl[2]; end
      default: begin cur_byte = work_q.byte2; cur_dbl = 1'b0; end
    endcase
  end

  assign byte_end = copy_q || !cur_dbl;
  assign item_end = byte_end && (work_q.frame_end ? (idx_q == 2'd2) : (idx_q == 2'd0));
  assign adv      = work_valid_q && (!out_valid_q || m_axis_tready);

  assign s_axis_tready = !work_valid_q || (adv && item_end);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign crc_new = crcfse_pkg::crc16_update(crc_q, s_axis_tdata);
  assign pos1    = pos_next(pos_q);
  assign pos2    = pos_next(pos1);

  always_comb begin
    crc_d        = crc_q;
    pos_d        = pos_q;
    work_d       = work_q;
    work_valid_d = work_valid_q;
    idx_d        = idx_q;
    copy_d       = copy_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_done_d   = out_done_q;

    // Sequencer: step through bytes and copies of the work register
    if (adv) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_last_d  = item_end;
      out_done_d  = item_end && work_q.frame_end;
      if (!byte_end) begin
        copy_d = 1'b1;
      end else begin
        copy_d = 1'b0;
        idx_d  = idx_q + 2'd1;
      end
      if (item_end) begin
        work_valid_d = 1'b0;
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // New request: fold into CRC, decide stuffing per frame position
    if (accept) begin
      work_valid_d     = 1'b1;
      idx_d            = 2'd0;
      copy_d           = 1'b0;
      work_d.byte0     = s_axis_tdata;
      work_d.byte1     = crc_new[7:0];
      work_d.byte2     = crc_new[15:8];
      work_d.frame_end = s_axis_tlast;
      work_d.dbl[0]    = (pos_q >= HdrPos) && (s_axis_tdata == escape_q);
      work_d.dbl[1]    = (pos1 >= HdrPos) && (crc_new[7:0] == escape_q);
      work_d.dbl[2]    = (pos2 >= HdrPos) && (crc_new[15:8] == escape_q);
      if (s_axis_tlast) begin
        crc_d = crcfse_pkg::CrcInit;
        pos_d = '0;
      end else begin
        crc_d = crc_new;
        pos_d = pos1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q        <= crcfse_pkg::CrcInit;
      pos_q        <= '0;
      escape_q     <= crcfse_pkg::EscapeReset;
      work_valid_q <= 1'b0;
      idx_q        <= 2'd0;
      copy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      crc_q        <= crc_d;
      pos_q        <= pos_d;
      work_valid_q <= work_valid_d;
      idx_q        <= idx_d;
      copy_q       <= copy_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        escape_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_byte_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_done_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_frame_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast) |=> (crc_q == crcfse_pkg::CrcInit && pos_q == '0))
    else $error("CRC/position not restored after frame end");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("frame_done without run_last");

  a_copy_only_dbl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work_valid_q && copy_q) |-> cur_dbl)
    else $error("second copy of a byte that is not doubled");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work_valid_q && !work_q.frame_end) |-> (idx_q == 2'd0))
    else $error("byte index past a single-byte request");

endmodule

`default_nettype wire
